FILE: design/cpd_pkg.sv
// Package for the CRC-16 packet deframer: item types, parser phases,
// status codes and the byte-wide CRC-16 (poly 0x1021) update function.
// No dependencies.
package cpd_pkg;

  localparam int unsigned MAX_PAYLOAD = 512;

  localparam logic [7:0]  SYNC_BYTE  = 8'h42;
  localparam logic [7:0]  ADDR_BCAST = 8'hff;
  localparam logic [7:0]  ADDR_ZERO  = 8'h00;
  localparam logic [15:0] CRC_POLY   = 16'h1021;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_ADDR   = 3'd1,
    PH_LEN_LO = 3'd2,
    PH_LEN_HI = 3'd3,
    PH_TYPE   = 3'd4,
    PH_DATA   = 3'd5,
    PH_CRC_LO = 3'd6,
    PH_CRC_HI = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CRC_ERR  = 2'd1,
    ST_BAD_ADDR = 2'd2,
    ST_OVERSIZE = 2'd3
  } status_e;

  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_RESET = 1'b1;

  localparam logic OUT_PAYLOAD = 1'b0;
  localparam logic OUT_STATUS  = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic        out_kind;
    logic [7:0]  payload_byte;
    logic [15:0] byte_index;
    logic [7:0]  pkt_type;
    logic [7:0]  pkt_addr;
    logic [15:0] pkt_len;
    logic [1:0]  status;
    logic        listen_match;
    logic        last;
  } out_t;

  // Request held in the input stage, as seen by the parser.
  typedef struct packed {
    logic valid;
    in_t  data;
  } stage_t;

  // Feed one byte into the CRC, MSB first.
  function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] data);
    logic [15:0] c;
    logic [7:0]  d;
    logic        top;
    c = crc;
    d = data;
    for (int i = 0; i < 8; i++) begin
      top = c[15];
      c   = {c[14:0], 1'b0};
      if (d[7] ^ top) begin
        c = c ^ CRC_POLY;
      end
      d = {d[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

FILE: design/crc16_packet_deframer.sv
// A request accepted into the input register is parsed combinationally and
//   its result is loaded into the output register for the consumer.
// Throughput: one request per cycle while the result register can take a
//   result, set by the single parse step between the input and result registers.
// Reset (rst_ni low, asynchronous): parser idle, header/CRC state and the
//   listen type cleared, both stages empty.
//
// Top level of the CRC-16 packet deframer. Depends on cpd_pkg, cpd_in_reg,
// cpd_parser and cpd_out_reg.
module crc16_packet_deframer #(
  parameter int unsigned MaxPayload = cpd_pkg::MAX_PAYLOAD
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cpd_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output cpd_pkg::out_t out_data_o,
  input  logic          cfg_we_i,
  input  logic [7:0]    cfg_wdata_i
);

  cpd_pkg::stage_t stage;
  cpd_pkg::out_t   res;
  logic            res_valid;
  logic            out_free;
  logic            step;

  // Advance the held request whenever the result register can take its
  // result; requests that make no result advance the same way.
  assign step = stage.valid && out_free;

  cpd_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .take_i     (step),
    .stage_o    (stage)
  );

  // Parse one byte: track header fields, feed the CRC, and build either a
  // payload item or the end-of-packet status item.
  cpd_parser #(
    .MaxPayload (MaxPayload)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .stage_i     (stage),
    .step_i      (step),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Hold a finished result here so a stalled consumer does not block the
  // input side until a further request is held in the input register.
  cpd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step && res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Status items and only they close a packet.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.last == out_data_o.out_kind))
    else $error("last flag disagrees with item kind");

  // A match is reported only on a good packet.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.listen_match) |->
      (out_data_o.status == cpd_pkg::ST_OK && out_data_o.out_kind == cpd_pkg::OUT_STATUS))
    else $error("listen match on a non-ok or payload item");

  // Payload item indices stay below the payload limit and the packet length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.out_kind == cpd_pkg::OUT_PAYLOAD) |->
      ({16'h0000, out_data_o.byte_index} < 32'(MaxPayload))
      && out_data_o.byte_index < out_data_o.pkt_len)
    else $error("payload index beyond limit or length");

  // Input stalls only while a request is held and the result side is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (stage.valid && out_valid_o && !out_ready_i))
    else $error("input stalled without a full pipeline");

endmodule

FILE: design/cpd_in_reg.sv
// Input register stage of the packet deframer: holds one request until the
// parser takes it. Depends on cpd_pkg.
module cpd_in_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  cpd_pkg::in_t    in_data_i,
  input  logic            take_i,
  output cpd_pkg::stage_t stage_o
);

  logic         valid_q, valid_d;
  cpd_pkg::in_t data_q;
  logic         accept;

  assign in_ready_o = !valid_q || take_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    priority if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= in_data_i;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.data  = data_q;

endmodule

FILE: design/cpd_parser.sv
// Header parser, CRC accumulator and status check of the packet deframer;
// also holds the listen type register. Depends on cpd_pkg.
module cpd_parser #(
  parameter int unsigned MaxPayload = cpd_pkg::MAX_PAYLOAD
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [7:0]      cfg_wdata_i,
  input  cpd_pkg::stage_t stage_i,
  input  logic            step_i,
  output logic            res_valid_o,
  output cpd_pkg::out_t   res_o
);

  localparam logic [15:0] MaxLen = 16'(MaxPayload);

  cpd_pkg::phase_e phase_q, phase_d;
  logic [7:0]      addr_q, addr_d;
  logic [15:0]     len_q, len_d;
  logic [7:0]      type_q, type_d;
  logic [15:0]     count_q, count_d;
  logic [15:0]     crc_q, crc_d;
  logic [7:0]      crc_lo_q, crc_lo_d;
  logic [7:0]      listen_q;

  logic        is_reset;
  logic [7:0]  b;
  logic [15:0] crc_next;
  logic [16:0] count_inc;
  logic        data_done;
  logic [15:0] rx_crc;
  cpd_pkg::status_e st;

  assign is_reset  = stage_i.data.kind == cpd_pkg::KIND_RESET;
  assign b         = stage_i.data.rx_byte;
  assign crc_next  = cpd_pkg::crc_feed(crc_q, b);
  assign count_inc = {1'b0, count_q} + 17'd1;
  assign data_done = count_inc >= {1'b0, len_q};
  assign rx_crc    = {b, crc_lo_q};

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    if (is_reset) begin
      phase_d = cpd_pkg::PH_IDLE;
    end else begin
      unique case (phase_q)
        cpd_pkg::PH_IDLE: begin
          if (b == cpd_pkg::SYNC_BYTE) phase_d = cpd_pkg::PH_ADDR;
        end
        cpd_pkg::PH_ADDR:   phase_d = cpd_pkg::PH_LEN_LO;
        cpd_pkg::PH_LEN_LO: phase_d = cpd_pkg::PH_LEN_HI;
        cpd_pkg::PH_LEN_HI: phase_d = cpd_pkg::PH_TYPE;
        cpd_pkg::PH_TYPE: begin
          phase_d = (len_q != '0) ? cpd_pkg::PH_DATA : cpd_pkg::PH_CRC_LO;
        end
        cpd_pkg::PH_DATA: begin
          if (data_done) phase_d = cpd_pkg::PH_CRC_LO;
        end
        cpd_pkg::PH_CRC_LO: phase_d = cpd_pkg::PH_CRC_HI;
        cpd_pkg::PH_CRC_HI: phase_d = cpd_pkg::PH_IDLE;
        default:            phase_d = cpd_pkg::PH_IDLE;
      endcase
    end
  end

  // Header, counter and CRC updates, and the result of this step.
  always_comb begin
    addr_d   = addr_q;
    len_d    = len_q;
    type_d   = type_q;
    count_d  = count_q;
    crc_d    = crc_q;
    crc_lo_d = crc_lo_q;

    priority if (len_q > MaxLen) begin
      st = cpd_pkg::ST_OVERSIZE;
    end else if (rx_crc != crc_q) begin
      st = cpd_pkg::ST_CRC_ERR;
    end else if (addr_q != cpd_pkg::ADDR_ZERO && addr_q != cpd_pkg::ADDR_BCAST) begin
      st = cpd_pkg::ST_BAD_ADDR;
    end else begin
      st = cpd_pkg::ST_OK;
    end

    res_valid_o        = 1'b0;
    res_o.out_kind     = cpd_pkg::OUT_PAYLOAD;
    res_o.payload_byte = b;
    res_o.byte_index   = count_q;
    res_o.pkt_type     = type_q;
    res_o.pkt_addr     = addr_q;
    res_o.pkt_len      = len_q;
    res_o.status       = cpd_pkg::ST_OK;
    res_o.listen_match = 1'b0;
    res_o.last         = 1'b0;

    if (!is_reset) begin
      unique case (phase_q)
        cpd_pkg::PH_IDLE: begin
          if (b == cpd_pkg::SYNC_BYTE) crc_d = cpd_pkg::crc_feed('0, b);
        end
        cpd_pkg::PH_ADDR: begin
          addr_d = b;
          crc_d  = crc_next;
        end
        cpd_pkg::PH_LEN_LO: begin
          len_d = {8'h00, b};
          crc_d = crc_next;
        end
        cpd_pkg::PH_LEN_HI: begin
          len_d = {b, len_q[7:0]};
          crc_d = crc_next;
        end
        cpd_pkg::PH_TYPE: begin
          type_d  = b;
          crc_d   = crc_next;
          count_d = '0;
        end
        cpd_pkg::PH_DATA: begin
          crc_d       = crc_next;
          count_d     = count_inc[15:0];
          // Drop bytes past the payload limit; they still enter the CRC.
          res_valid_o = count_q < MaxLen;
        end
        cpd_pkg::PH_CRC_LO: begin
          crc_lo_d = b;
        end
        cpd_pkg::PH_CRC_HI: begin
          res_valid_o        = 1'b1;
          res_o.out_kind     = cpd_pkg::OUT_STATUS;
          res_o.payload_byte = '0;
          res_o.byte_index   = '0;
          res_o.status       = st;
          res_o.listen_match = (st == cpd_pkg::ST_OK) && (type_q == listen_q);
          res_o.last         = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= cpd_pkg::PH_IDLE;
      addr_q   <= '0;
      len_q    <= '0;
      type_q   <= '0;
      count_q  <= '0;
      crc_q    <= '0;
      crc_lo_q <= '0;
    end else if (step_i && stage_i.valid) begin
      phase_q  <= phase_d;
      addr_q   <= addr_d;
      len_q    <= len_d;
      type_q   <= type_d;
      count_q  <= count_d;
      crc_q    <= crc_d;
      crc_lo_q <= crc_lo_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      listen_q <= '0;
    end else if (cfg_we_i) begin
      listen_q <= cfg_wdata_i;
    end
  end

endmodule

FILE: design/cpd_out_reg.sv
// Result register of the packet deframer: holds one result until the
// consumer takes it. Depends on cpd_pkg.
module cpd_out_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  cpd_pkg::out_t res_i,
  output logic          free_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output cpd_pkg::out_t out_data_o
);

  logic          valid_q, valid_d;
  cpd_pkg::out_t data_q;

  assign free_o  = !valid_q || out_ready_i;
  assign valid_d = load_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule
